// ===== rtl/core/free_list_page_allocator_assert.svh =====
// assertion macros for the free list page allocator
`ifndef FREE_LIST_PAGE_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_PAGE_ALLOCATOR_ASSERT_SVH

// condition holds, consequence must hold in the same cycle
`define FLPA_ASSERT_SAME(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// condition holds, consequence must hold in the next cycle
`define FLPA_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== rtl/core/flpa_pkg.sv =====
// shared types and constants of the free list page allocator
package flpa_pkg;

   localparam int ADDR_W  = 56;
   localparam int REQ_W   = 2;
   localparam int STS_W   = 2;
   localparam int FREE_W  = 16;
   localparam int CSR_IDX_W = 1;

   localparam int MAX_PAGES_DEF  = 32768;
   localparam int PAGE_BYTES_DEF = 4096;

   localparam logic [ADDR_W-1:0] MEM_START_RST = ADDR_W'(64'h0000_0000_8000_0000);
   localparam logic [ADDR_W-1:0] MEM_TOP_RST   = ADDR_W'(64'h0000_0000_8800_0000);

   // request codes
   localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

   // result status codes
   localparam logic [STS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] ST_BAD   = 2'd2;
   localparam logic [STS_W-1:0] ST_FULL  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_TOP   = 1'd1;

   typedef struct packed {
      logic capture;
      logic exec;
      logic init_range;
      logic init_limit;
      logic fill_step;
      logic load_out;
      logic load_read;
   } flpa_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] op;
      logic             cnt_zero;
      logic             fill_done;
   } flpa_sts_type;

endpackage

// ===== rtl/core/flpa_chan_if.sv =====
// handshake channel interfaces of the free list page allocator
interface flpa_req_if;
   logic                            valid;
   logic                            ready;
   logic [flpa_pkg::REQ_W-1:0]      req_type;
   logic [flpa_pkg::ADDR_W-1:0]     page_addr;

   modport source (output valid, output req_type, output page_addr, input ready);
   modport sink   (input valid, input req_type, input page_addr, output ready);
endinterface

interface flpa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [flpa_pkg::ADDR_W-1:0]     alloc_addr;
   logic [flpa_pkg::STS_W-1:0]      status;
   logic [flpa_pkg::FREE_W-1:0]     free_pages;

   modport source (output valid, output alloc_addr, output status, output free_pages,
                   input ready);
   modport sink   (input valid, input alloc_addr, input status, input free_pages,
                   output ready);
endinterface

interface flpa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [flpa_pkg::CSR_IDX_W-1:0]  index;
   logic [flpa_pkg::ADDR_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/flpa_ram.sv =====
// generic single port write, registered read ram
module flpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/flpa_ctrl.sv =====
// sequencing state machine of the free list page allocator
module flpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  flpa_pkg::flpa_sts_type sts,
   output flpa_pkg::flpa_cmd_type cmd
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_EXEC       = 3'd1;
   localparam logic [2:0] S_READ       = 3'd2;
   localparam logic [2:0] S_INIT_RANGE = 3'd3;
   localparam logic [2:0] S_INIT_LIMIT = 3'd4;
   localparam logic [2:0] S_FILL       = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // output slot is free when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.op == flpa_pkg::REQ_INIT) begin
               cmd.exec = 1'b1;
               state_in = S_INIT_RANGE;
            end else if (sts.op == flpa_pkg::REQ_ALLOC && !sts.cnt_zero) begin
               cmd.exec = 1'b1;
               state_in = S_READ;
            end else if (out_free) begin
               cmd.exec     = 1'b1;
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               cmd.load_out  = 1'b1;
               cmd.load_read = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_INIT_RANGE: begin
            cmd.init_range = 1'b1;
            state_in       = S_INIT_LIMIT;
         end
         S_INIT_LIMIT: begin
            cmd.init_limit = 1'b1;
            state_in       = S_FILL;
         end
         S_FILL: begin
            if (!sts.fill_done) begin
               cmd.fill_step = 1'b1;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/flpa_dp.sv =====
// datapath of the free list page allocator: registers, checks and page stack
module flpa_dp #(
   parameter int MAX_PAGES  = flpa_pkg::MAX_PAGES_DEF,
   parameter int PAGE_BYTES = flpa_pkg::PAGE_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  flpa_pkg::flpa_cmd_type            cmd,
   output flpa_pkg::flpa_sts_type            sts,
   input  logic                              csr_we,
   input  logic [flpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [flpa_pkg::ADDR_W-1:0]       csr_data,
   input  logic [flpa_pkg::REQ_W-1:0]        req_type,
   input  logic [flpa_pkg::ADDR_W-1:0]       page_addr,
   output logic [flpa_pkg::ADDR_W-1:0]       alloc_addr,
   output logic [flpa_pkg::STS_W-1:0]        status,
   output logic [flpa_pkg::FREE_W-1:0]       free_pages
);

   localparam int ADDR_W = flpa_pkg::ADDR_W;
   localparam int OFF_W  = $clog2(PAGE_BYTES);
   localparam int PN_W   = ADDR_W - OFF_W;
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int AW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int EXT_W  = (CNT_W > flpa_pkg::FREE_W) ? CNT_W : flpa_pkg::FREE_W;
   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_PAGES);
   localparam logic [PN_W-1:0]   MAX_PN  = PN_W'(MAX_PAGES);
   localparam logic [ADDR_W:0]   OFF_ADD = (ADDR_W + 1)'(PAGE_BYTES - 1);

   logic [ADDR_W-1:0]          start_ff, start_in;
   logic [ADDR_W-1:0]          top_ff, top_in;
   logic [flpa_pkg::REQ_W-1:0] op_ff;
   logic [ADDR_W-1:0]          pa_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [PN_W-1:0]            pn_ff, pn_in;
   logic                       ovf_ff, ovf_in;
   logic [PN_W-1:0]            npages_ff, npages_in;
   logic                       empty_ff, empty_in;
   logic [CNT_W-1:0]           limit_ff, limit_in;
   logic [flpa_pkg::STS_W-1:0] init_st_ff, init_st_in;
   logic [ADDR_W-1:0]          alloc_addr_ff, alloc_addr_in;
   logic [flpa_pkg::STS_W-1:0] status_ff, status_in;
   logic [flpa_pkg::FREE_W-1:0] free_pages_ff, free_pages_in;

   logic                       pa_bad;
   logic                       stack_full;
   logic                       cnt_zero;
   logic [CNT_W-1:0]           cnt_dec;
   logic [ADDR_W:0]            sum_start;
   logic [ADDR_W-1:0]          base;
   logic [ADDR_W-1:0]          diff;
   logic [flpa_pkg::STS_W-1:0] free_st;
   logic [EXT_W-1:0]           count_ext;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [PN_W-1:0]            wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [PN_W-1:0]            rd_data;

   flpa_ram #(
      .WIDTH (PN_W),
      .DEPTH (MAX_PAGES)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pa_bad     = (pa_ff[OFF_W-1:0] != '0) || (pa_ff < start_ff) || (pa_ff >= top_ff);
   assign stack_full = (count_ff == MAX_CNT);
   assign cnt_zero   = (count_ff == '0);
   assign cnt_dec    = count_ff - CNT_W'(1);
   // rounding up carries out of the address space when the start lies in the last page, past its first byte
   assign sum_start  = {1'b0, start_ff} + OFF_ADD;
   assign base       = {pn_ff, {OFF_W{1'b0}}};
   assign diff       = top_ff - base;

   assign sts.op        = op_ff;
   assign sts.cnt_zero  = cnt_zero;
   assign sts.fill_done = (count_ff == limit_ff);

   always_comb begin
      if (pa_bad) begin
         free_st = flpa_pkg::ST_BAD;
      end else if (stack_full) begin
         free_st = flpa_pkg::ST_FULL;
      end else begin
         free_st = flpa_pkg::ST_OK;
      end
   end

   always_comb begin
      count_in   = count_ff;
      pn_in      = pn_ff;
      ovf_in     = ovf_ff;
      npages_in  = npages_ff;
      empty_in   = empty_ff;
      limit_in   = limit_ff;
      init_st_in = init_st_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = pa_ff[ADDR_W-1:OFF_W];
      rd_en      = 1'b0;
      rd_addr    = cnt_dec[AW-1:0];

      if (cmd.exec) begin
         case (op_ff)
            flpa_pkg::REQ_INIT: begin
               count_in = '0;
               pn_in    = sum_start[ADDR_W-1:OFF_W];
               ovf_in   = sum_start[ADDR_W];
            end
            flpa_pkg::REQ_ALLOC: begin
               if (!cnt_zero) begin
                  count_in = cnt_dec;
                  rd_en    = 1'b1;
               end
            end
            flpa_pkg::REQ_FREE: begin
               if (!pa_bad && !stack_full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.init_range) begin
         empty_in  = ovf_ff || (top_ff < base);
         npages_in = diff[ADDR_W-1:OFF_W];
      end

      if (cmd.init_limit) begin
         if (empty_ff) begin
            limit_in   = '0;
            init_st_in = flpa_pkg::ST_OK;
         end else if (npages_ff > MAX_PN) begin
            // highest pages beyond the stack depth are dropped
            limit_in   = MAX_CNT;
            init_st_in = flpa_pkg::ST_FULL;
         end else begin
            limit_in   = npages_ff[CNT_W-1:0];
            init_st_in = flpa_pkg::ST_OK;
         end
      end

      if (cmd.fill_step) begin
         wr_en    = 1'b1;
         wr_data  = pn_ff;
         pn_in    = pn_ff + PN_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      start_in = start_ff;
      top_in   = top_ff;
      if (csr_we) begin
         case (csr_index)
            flpa_pkg::CSR_MEM_START: start_in = csr_data;
            flpa_pkg::CSR_MEM_TOP:   top_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      count_ext     = EXT_W'(count_in);
      free_pages_in = count_ext[flpa_pkg::FREE_W-1:0];
      alloc_addr_in = '0;
      if (cmd.load_read) begin
         alloc_addr_in = {rd_data, {OFF_W{1'b0}}};
         status_in     = flpa_pkg::ST_OK;
      end else begin
         case (op_ff)
            flpa_pkg::REQ_INIT:  status_in = init_st_ff;
            flpa_pkg::REQ_ALLOC: status_in = flpa_pkg::ST_EMPTY;
            flpa_pkg::REQ_FREE:  status_in = free_st;
            default:             status_in = flpa_pkg::ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= flpa_pkg::MEM_START_RST;
         top_ff   <= flpa_pkg::MEM_TOP_RST;
         count_ff <= '0;
      end else begin
         start_ff <= start_in;
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_type;
         pa_ff <= page_addr;
      end
      pn_ff      <= pn_in;
      ovf_ff     <= ovf_in;
      npages_ff  <= npages_in;
      empty_ff   <= empty_in;
      limit_ff   <= limit_in;
      init_st_ff <= init_st_in;
      if (cmd.load_out) begin
         alloc_addr_ff <= alloc_addr_in;
         status_ff     <= status_in;
         free_pages_ff <= free_pages_in;
      end
   end

   assign alloc_addr = alloc_addr_ff;
   assign status     = status_ff;
   assign free_pages = free_pages_ff;

endmodule

// ===== rtl/core/free_list_page_allocator.sv =====
// Free list page allocator: LIFO stack of free physical page numbers.
// req_if carries one request item: req_type (init, alloc, free, no-op) and
// page_addr (the page to free). rsp_if returns exactly one item per request:
// alloc_addr, status and free_pages (stack depth after the request, low 16 bits).
// csr_if writes mem_start (index 0) and mem_top (index 1) and is always ready;
// it is to be written only while no request is in flight, which the block does not enforce.
// Sequence: a request is taken in the idle state; free, no-op and an alloc on an
// empty stack load the result in the exec state, while an alloc that pops reads
// the stack memory in the exec state and loads the result in the read state.
// Init passes the exec, range and limit states, then pushes one page per cycle
// through the single write port of the stack memory in the fill state before
// it loads its result.
// Reset clears the stack count and sets mem_start/mem_top to their defaults;
// stack memory contents are not cleared, entries above the count are never read.
// The result sits in an output register; while the receiver stalls the block
// still accepts the next request and works it up to its final step, where it
// waits for the output register to drain.
module free_list_page_allocator #(
   parameter int MAX_PAGES  = flpa_pkg::MAX_PAGES_DEF,
   parameter int PAGE_BYTES = flpa_pkg::PAGE_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   flpa_req_if.sink      req_if,
   flpa_rsp_if.source    rsp_if,
   flpa_csr_if.sink      csr_if
);

   flpa_pkg::flpa_cmd_type cmd;
   flpa_pkg::flpa_sts_type sts;

   assign csr_if.ready = 1'b1;

   flpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   flpa_dp #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_if.valid),
      .csr_index  (csr_if.index),
      .csr_data   (csr_if.data),
      .req_type   (req_if.req_type),
      .page_addr  (req_if.page_addr),
      .alloc_addr (rsp_if.alloc_addr),
      .status     (rsp_if.status),
      .free_pages (rsp_if.free_pages)
   );

   localparam logic [flpa_pkg::FREE_W-1:0] FULL_PAGES = flpa_pkg::FREE_W'(MAX_PAGES);

   logic req_take;
   logic rsp_empty;
   logic rsp_full;
   logic no_page;
   logic cnt_zero;
   logic cnt_full;

   assign req_take  = req_if.valid && req_if.ready;
   assign rsp_empty = rsp_if.valid && (rsp_if.status == flpa_pkg::ST_EMPTY);
   assign rsp_full  = rsp_if.valid && (rsp_if.status == flpa_pkg::ST_FULL);
   assign no_page   = (rsp_if.alloc_addr == '0);
   assign cnt_zero  = (rsp_if.free_pages == '0);
   assign cnt_full  = (rsp_if.free_pages == FULL_PAGES);

`include "free_list_page_allocator_assert.svh"

   `FLPA_ASSERT_NEXT(a_one_item_at_a_time, req_take, !req_if.ready, "request taken while busy")
   `FLPA_ASSERT_SAME(a_empty_result, rsp_empty, no_page && cnt_zero, "bad empty reply")
   `FLPA_ASSERT_SAME(a_full_count, rsp_full, no_page && cnt_full, "bad full reply")

endmodule
